>>> hdl/fpat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpat_pkg: shared types and constants of the fixed-point atan2 block
// Widths of the datapath, angle constants and the payload carried by the
// stages of the pipeline.
// ----------------------------------------------------------------------------
package fpat_pkg;

  localparam int MagW  = 31;   // magnitude of a clamped 32-bit input
  localparam int RemW  = 32;   // partial remainder, one bit above MagW
  localparam int QuoW  = 17;   // ratio 0 .. 0x10000 in 1.16
  localparam int NCell = QuoW; // one divider cell per quotient bit
  localparam int InnW  = 12;   // slope term, at most 0x0B20
  localparam int SumW  = 14;   // 0x2000 plus slope term, at most 0x2B20
  localparam int OctW  = 14;   // first-octant angle, at most 0x2000
  localparam int AngW  = 16;

  localparam logic [AngW-1:0] AngZeroVec = 16'hC000;
  localparam logic [AngW-1:0] AngEighth  = 16'h2000;
  localparam logic [InnW-1:0] AngSlope   = 12'hB20;
  localparam logic [QuoW-1:0] FxOne      = 17'h10000;
  localparam logic [AngW-1:0] AngQuarter = 16'h4000;
  localparam logic [AngW-1:0] AngHalf    = 16'h8000;

  // Octant folding flags that travel alongside the arithmetic.
  typedef struct packed {
    logic zero;
    logic swap;
    logic mirror;
    logic negate;
  } fold_t;

  // Payload handed from one divider cell to the next.
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [MagW-1:0] den;
    logic [QuoW-1:0] quo;
    fold_t           fold;
  } dcell_t;

endpackage

>>> hdl/fixed_point_atan2_turns.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_atan2_turns: screen-space atan2 returning a turn fraction
// Pipelined octant approximation of the angle of a signed 16.16 vector.
// ----------------------------------------------------------------------------
// The block accepts one request in every clock cycle while the result side
// keeps taking results. Each request passes through the input stage, the
// chain of division cells (one quotient bit per cell), the two multiply
// stages and the folding output register. Every stage holds its own valid
// bit, so bubbles are squeezed out and a request is still taken while a
// finished result waits at the output and some stage is free. The angle is
// counted counterclockwise from +x with y pointing up, 65536 counts to a
// full turn; the zero vector gives 0xC000 and an input of -2^31 is treated
// as -2^31+1.
// ----------------------------------------------------------------------------
module fixed_point_atan2_turns (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_delta_x,
  input  logic signed [31:0] in_delta_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_angle_turns
);

  // Index 0 is the input stage; index k+1 is the output of division cell k.
  logic [fpat_pkg::NCell:0] div_vld;
  logic [fpat_pkg::NCell:0] div_rdy;
  fpat_pkg::dcell_t         div_dat [fpat_pkg::NCell+1];
  logic                     poly_rdy;

  fpat_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (in_valid),
    .rdy_o  (in_ready),
    .dx_i   (in_delta_x),
    .dy_i   (in_delta_y),
    .vld_o  (div_vld[0]),
    .rdy_i  (div_rdy[0]),
    .data_o (div_dat[0])
  );

  // Each cell settles one bit of the ratio, from the 1.0 bit downwards.
  for (genvar k = 0; k < fpat_pkg::NCell; k++) begin : g_cell
    fpat_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (div_vld[k]),
      .rdy_o  (div_rdy[k]),
      .data_i (div_dat[k]),
      .vld_o  (div_vld[k+1]),
      .rdy_i  (div_rdy[k+1]),
      .data_o (div_dat[k+1])
    );
  end

  assign div_rdy[fpat_pkg::NCell] = poly_rdy;

  fpat_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (div_vld[fpat_pkg::NCell]),
    .rdy_o   (poly_rdy),
    .ratio_i (div_dat[fpat_pkg::NCell].quo),
    .fold_i  (div_dat[fpat_pkg::NCell].fold),
    .vld_o   (out_valid),
    .rdy_i   (out_ready),
    .angle_o (out_angle_turns)
  );

  // The input side can only stall once every stage ahead of it is occupied.
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&div_vld) && out_valid)
    else $error("input stalled while the pipeline has a free stage");

  // A ratio of exactly one has no fractional bits. The zero vector divides
  // by zero and carries a meaningless ratio, which the fold replaces.
  a_ratio_max : assert property (@(posedge clk) disable iff (!rst_n)
    div_vld[fpat_pkg::NCell] && !div_dat[fpat_pkg::NCell].fold.zero &&
    div_dat[fpat_pkg::NCell].quo[fpat_pkg::QuoW-1]
    |-> div_dat[fpat_pkg::NCell].quo[fpat_pkg::QuoW-2:0] == '0)
    else $error("division ratio exceeds one");

  // A zero denominator only ever comes from the zero vector.
  a_zero_den : assert property (@(posedge clk) disable iff (!rst_n)
    div_vld[0] && (div_dat[0].den == '0) |-> div_dat[0].fold.zero)
    else $error("zero denominator on a non-zero vector");

endmodule

>>> hdl/fpat_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpat_front: input stage
// Takes magnitudes with clamping, works out the folding flags and orders the
// pair so that the numerator does not exceed the denominator.
// ----------------------------------------------------------------------------
module fpat_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   vld_i,
  output logic                   rdy_o,
  input  logic signed [31:0]     dx_i,
  input  logic signed [31:0]     dy_i,
  output logic                   vld_o,
  input  logic                   rdy_i,
  output fpat_pkg::dcell_t       data_o
);

  logic                          vld_r;
  fpat_pkg::dcell_t              data_r;
  fpat_pkg::dcell_t              data_nxt;
  logic [fpat_pkg::MagW-1:0]     ax;
  logic [fpat_pkg::MagW-1:0]     ay;
  logic [31:0]                   neg_x;
  logic [31:0]                   neg_y;

  // The most negative value is clamped before its magnitude is taken.
  assign neg_x = 32'd0 - dx_i;
  assign neg_y = 32'd0 - dy_i;
  assign ax = !dx_i[31] ? dx_i[fpat_pkg::MagW-1:0] :
              (dx_i == 32'sh8000_0000) ? {fpat_pkg::MagW{1'b1}} :
              neg_x[fpat_pkg::MagW-1:0];
  assign ay = !dy_i[31] ? dy_i[fpat_pkg::MagW-1:0] :
              (dy_i == 32'sh8000_0000) ? {fpat_pkg::MagW{1'b1}} :
              neg_y[fpat_pkg::MagW-1:0];

  always_comb begin
    data_nxt.fold.zero   = (dx_i == 32'sd0) && (dy_i == 32'sd0);
    data_nxt.fold.swap   = ay > ax;
    data_nxt.fold.mirror = dx_i[31];
    // Screen y points down, so a positive delta_y is a negative math angle.
    data_nxt.fold.negate = !dy_i[31] && (dy_i != 32'sd0);
    data_nxt.quo         = '0;
    if (ay > ax) begin
      data_nxt.rem = {1'b0, ax};
      data_nxt.den = ay;
    end else begin
      data_nxt.rem = {1'b0, ay};
      data_nxt.den = ax;
    end
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

>>> hdl/fpat_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpat_div_cell: one restoring division cell
// Resolves one quotient bit, most significant first, and hands the doubled
// partial remainder to the next cell.
// ----------------------------------------------------------------------------
module fpat_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  output logic             rdy_o,
  input  fpat_pkg::dcell_t data_i,
  output logic             vld_o,
  input  logic             rdy_i,
  output fpat_pkg::dcell_t data_o
);

  logic                        vld_r;
  fpat_pkg::dcell_t            data_r;
  fpat_pkg::dcell_t            data_nxt;
  logic                        bit_q;
  logic [fpat_pkg::RemW-1:0]   den_ext;
  logic [fpat_pkg::RemW-1:0]   diff;

  assign den_ext = {1'b0, data_i.den};
  assign bit_q   = data_i.rem >= den_ext;
  assign diff    = bit_q ? (data_i.rem - den_ext) : data_i.rem;

  always_comb begin
    data_nxt      = data_i;
    // The remainder stays below the denominator, so doubling it cannot overflow.
    data_nxt.rem  = {diff[fpat_pkg::RemW-2:0], 1'b0};
    data_nxt.quo  = {data_i.quo[fpat_pkg::QuoW-2:0], bit_q};
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

>>> hdl/fpat_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpat_poly: octant polynomial and fold
// Two registered multiply stages evaluate the first-octant angle, and the
// output stage folds it into the full turn.
// ----------------------------------------------------------------------------
module fpat_poly (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  output logic                        rdy_o,
  input  logic [fpat_pkg::QuoW-1:0]   ratio_i,
  input  fpat_pkg::fold_t             fold_i,
  output logic                        vld_o,
  input  logic                        rdy_i,
  output logic [fpat_pkg::AngW-1:0]   angle_o
);

  // Stage A: slope term.
  logic                          a_vld_r;
  logic                          a_rdy;
  logic [fpat_pkg::QuoW-1:0]     a_ratio_r;
  logic [fpat_pkg::InnW-1:0]     a_inner_r;
  fpat_pkg::fold_t               a_fold_r;
  logic [fpat_pkg::QuoW-1:0]     one_minus;
  logic [28:0]                   inner_prod;
  // Stage B: octant angle.
  logic                          b_vld_r;
  logic                          b_rdy;
  logic [fpat_pkg::OctW-1:0]     b_oct_r;
  fpat_pkg::fold_t               b_fold_r;
  logic [fpat_pkg::SumW-1:0]     sum;
  logic [30:0]                   oct_prod;
  // Stage C: folded result.
  logic                          c_vld_r;
  logic                          c_rdy;
  logic [fpat_pkg::AngW-1:0]     c_ang_r;
  logic [fpat_pkg::AngW-1:0]     ang_nxt;
  logic [fpat_pkg::AngW-1:0]     res;

  assign one_minus  = fpat_pkg::FxOne - ratio_i;
  assign inner_prod = 29'(fpat_pkg::AngSlope) * 29'(one_minus);

  assign sum      = fpat_pkg::SumW'(fpat_pkg::AngEighth) + fpat_pkg::SumW'(a_inner_r);
  assign oct_prod = 31'(a_ratio_r) * 31'(sum);

  always_comb begin
    res = fpat_pkg::AngW'(b_oct_r);
    if (b_fold_r.swap) begin
      res = fpat_pkg::AngQuarter - res;
    end
    if (b_fold_r.mirror) begin
      res = fpat_pkg::AngHalf - res;
    end
    if (b_fold_r.negate) begin
      res = '0 - res;
    end
    ang_nxt = b_fold_r.zero ? fpat_pkg::AngZeroVec : res;
  end

  assign c_rdy = !c_vld_r || rdy_i;
  assign b_rdy = !b_vld_r || c_rdy;
  assign a_rdy = !a_vld_r || b_rdy;
  assign rdy_o = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= vld_i;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
      if (c_rdy) begin
        c_vld_r <= b_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && vld_i) begin
      a_ratio_r <= ratio_i;
      a_inner_r <= inner_prod[16 +: fpat_pkg::InnW];
      a_fold_r  <= fold_i;
    end
    if (b_rdy && a_vld_r) begin
      b_oct_r  <= oct_prod[16 +: fpat_pkg::OctW];
      b_fold_r <= a_fold_r;
    end
    if (c_rdy && b_vld_r) begin
      c_ang_r <= ang_nxt;
    end
  end

  assign vld_o   = c_vld_r;
  assign angle_o = c_ang_r;

endmodule
